// ===== hw/rtl/rmq_pkg.sv =====
// rmq_pkg: widths, constants and types for the rotation matrix to quaternion block.
// Used by rmq_front, rmq_sqrt, rmq_div and the top level; depends on nothing.
package rmq_pkg;

  localparam int DATA_WIDTH = 16;
  localparam int FRAC_BITS  = DATA_WIDTH - 2;
  localparam int CAND_W     = DATA_WIDTH + 2;
  localparam int SUM_W      = DATA_WIDTH + 1;
  localparam int RAD_W      = CAND_W - 1 + FRAC_BITS - 2;
  localparam int ROOT_W     = (RAD_W + 1) / 2;
  localparam int X_W        = 2 * ROOT_W;
  localparam int SREM_W     = ROOT_W + 3;
  localparam int V_W        = ROOT_W + 1;
  localparam int MAG_W      = SUM_W + FRAC_BITS - 2;
  localparam int NUM_W      = MAG_W + 2;
  localparam int DEN_W      = V_W + 1;
  localparam int DREM_W     = DEN_W + 1;
  localparam int LATENCY    = ROOT_W + NUM_W + 4;

  typedef logic signed [DATA_WIDTH-1:0] word_t;
  typedef logic signed [SUM_W-1:0]      sum_t;
  typedef logic signed [CAND_W-1:0]     cand_t;
  typedef logic [1:0]                   sel_t;

  localparam sel_t SEL_X = 2'd0;
  localparam sel_t SEL_Y = 2'd1;
  localparam sel_t SEL_Z = 2'd2;
  localparam sel_t SEL_W = 2'd3;

  localparam cand_t ONE_Q = cand_t'(longint'(1) << FRAC_BITS);
  localparam longint Q_MAX = (longint'(1) << (DATA_WIDTH - 1)) - 1;

  // travels alongside the square root
  typedef struct packed {
    sel_t            best;
    logic            fault;
    sum_t [2:0]      lane_sum;
  } sq_side_t;

  // travels alongside the dividers
  typedef struct packed {
    sel_t            best;
    logic            fault;
    logic [V_W-1:0]  v;
    logic [2:0]      neg;
  } dv_side_t;

endpackage

// ===== hw/rtl/rmq_front.sv =====
// rmq_front: candidate terms, largest-term selection and off-diagonal lane sums.
// Two register stages; depends on rmq_pkg.
module rmq_front (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_vld,
  input  rmq_pkg::word_t [8:0]            mat,
  output logic                            out_vld,
  output logic [rmq_pkg::RAD_W-1:0]       radicand,
  output rmq_pkg::sq_side_t               side
);
  import rmq_pkg::*;

  logic          vld1_r;
  cand_t [3:0]   cand_r;
  sum_t          sxy_r, szx_r, syz_r, dx_r, dy_r, dz_r;

  cand_t [3:0]   cand_nxt;
  cand_t         e00, e11, e22;

  logic              vld2_r;
  logic [RAD_W-1:0]  rad_r;
  sq_side_t          side_r;

  sel_t              best;
  cand_t             cbest;
  logic              fault;
  sum_t [2:0]        lanes;

  always_comb begin
    e00 = cand_t'(mat[0]);
    e11 = cand_t'(mat[4]);
    e22 = cand_t'(mat[8]);
    cand_nxt[0] = e00 - e11 - e22 + ONE_Q;
    cand_nxt[1] = -e00 + e11 - e22 + ONE_Q;
    cand_nxt[2] = -e00 - e11 + e22 + ONE_Q;
    cand_nxt[3] = e00 + e11 + e22 + ONE_Q;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld1_r <= 1'b0;
    end else begin
      vld1_r <= in_vld;
    end
    cand_r <= cand_nxt;
    sxy_r  <= sum_t'(mat[1]) + sum_t'(mat[3]);
    szx_r  <= sum_t'(mat[6]) + sum_t'(mat[2]);
    syz_r  <= sum_t'(mat[5]) + sum_t'(mat[7]);
    dx_r   <= sum_t'(mat[5]) - sum_t'(mat[7]);
    dy_r   <= sum_t'(mat[6]) - sum_t'(mat[2]);
    dz_r   <= sum_t'(mat[1]) - sum_t'(mat[3]);
  end

  // first candidate wins on ties
  always_comb begin
    best  = SEL_X;
    cbest = cand_r[0];
    if (cand_r[1] > cbest) begin
      best  = SEL_Y;
      cbest = cand_r[1];
    end
    if (cand_r[2] > cbest) begin
      best  = SEL_Z;
      cbest = cand_r[2];
    end
    if (cand_r[3] > cbest) begin
      best  = SEL_W;
      cbest = cand_r[3];
    end
    fault = (cbest <= 0);
    case (best)
      SEL_X: begin
        lanes[0] = sxy_r; lanes[1] = szx_r; lanes[2] = dx_r;
      end
      SEL_Y: begin
        lanes[0] = sxy_r; lanes[1] = syz_r; lanes[2] = dy_r;
      end
      SEL_Z: begin
        lanes[0] = szx_r; lanes[1] = syz_r; lanes[2] = dz_r;
      end
      default: begin
        lanes[0] = dx_r;  lanes[1] = dy_r;  lanes[2] = dz_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld2_r <= 1'b0;
    end else begin
      vld2_r <= vld1_r;
    end
    rad_r           <= fault ? '0 : (RAD_W'(cbest[CAND_W-2:0]) << (FRAC_BITS - 2));
    side_r.best     <= best;
    side_r.fault    <= fault;
    side_r.lane_sum <= lanes;
  end

  assign out_vld  = vld2_r;
  assign radicand = rad_r;
  assign side     = side_r;

endmodule

// ===== hw/rtl/rmq_sqrt.sv =====
// rmq_sqrt: pipelined digit-by-digit integer square root, one result bit per stage.
// Gives floor root and remainder; depends on rmq_pkg.
module rmq_sqrt (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_vld,
  input  logic [rmq_pkg::RAD_W-1:0]      radicand,
  input  rmq_pkg::sq_side_t              side_in,
  output logic                           out_vld,
  output logic [rmq_pkg::ROOT_W-1:0]     root,
  output logic [rmq_pkg::SREM_W-1:0]     rem,
  output rmq_pkg::sq_side_t              side_out
);
  import rmq_pkg::*;

  logic              vld_r  [ROOT_W];
  logic [X_W-1:0]    x_r    [ROOT_W];
  logic [ROOT_W-1:0] root_r [ROOT_W];
  logic [SREM_W-1:0] rem_r  [ROOT_W];
  sq_side_t          side_r [ROOT_W];

  for (genvar i = 0; i < ROOT_W; i++) begin : g_step
    logic              vld_in;
    logic [X_W-1:0]    x_in;
    logic [ROOT_W-1:0] root_in;
    logic [SREM_W-1:0] rem_in;
    sq_side_t          side_i;
    logic [SREM_W-1:0] rem_t, trial, rem_nxt;
    logic [ROOT_W-1:0] root_nxt;

    if (i == 0) begin : g_head
      assign vld_in  = in_vld;
      assign x_in    = X_W'(radicand);
      assign root_in = '0;
      assign rem_in  = '0;
      assign side_i  = side_in;
    end else begin : g_body
      assign vld_in  = vld_r[i-1];
      assign x_in    = x_r[i-1];
      assign root_in = root_r[i-1];
      assign rem_in  = rem_r[i-1];
      assign side_i  = side_r[i-1];
    end

    always_comb begin
      rem_t = {rem_in[SREM_W-3:0], x_in[X_W-1 -: 2]};
      trial = SREM_W'({root_in, 2'b01});
      if (rem_t >= trial) begin
        rem_nxt  = rem_t - trial;
        root_nxt = {root_in[ROOT_W-2:0], 1'b1};
      end else begin
        rem_nxt  = rem_t;
        root_nxt = {root_in[ROOT_W-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[i] <= 1'b0;
      end else begin
        vld_r[i] <= vld_in;
      end
      x_r[i]    <= x_in << 2;
      root_r[i] <= root_nxt;
      rem_r[i]  <= rem_nxt;
      side_r[i] <= side_i;
    end
  end

  assign out_vld  = vld_r[ROOT_W-1];
  assign root     = root_r[ROOT_W-1];
  assign rem      = rem_r[ROOT_W-1];
  assign side_out = side_r[ROOT_W-1];

endmodule

// ===== hw/rtl/rmq_div.sv =====
// rmq_div: three-lane pipelined restoring divider, one quotient bit per stage.
// All lanes share the divisor 2v held in the sideband; depends on rmq_pkg.
module rmq_div (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_vld,
  input  logic [2:0][rmq_pkg::NUM_W-1:0]      num,
  input  rmq_pkg::dv_side_t                   side_in,
  output logic                                out_vld,
  output logic [2:0][rmq_pkg::NUM_W-1:0]      quot,
  output rmq_pkg::dv_side_t                   side_out
);
  import rmq_pkg::*;

  logic                         vld_r  [NUM_W];
  logic [2:0][NUM_W-1:0]        n_r    [NUM_W];
  logic [2:0][NUM_W-1:0]        q_r    [NUM_W];
  logic [2:0][DREM_W-1:0]       rem_r  [NUM_W];
  dv_side_t                     side_r [NUM_W];

  for (genvar i = 0; i < NUM_W; i++) begin : g_step
    logic                   vld_in;
    logic [2:0][NUM_W-1:0]  n_in, q_in, q_nxt;
    logic [2:0][DREM_W-1:0] rem_in, rem_nxt;
    dv_side_t               side_i;
    logic [DREM_W-1:0]      den;
    logic [DREM_W-1:0]      rem_t;

    if (i == 0) begin : g_head
      assign vld_in = in_vld;
      assign n_in   = num;
      assign q_in   = '0;
      assign rem_in = '0;
      assign side_i = side_in;
    end else begin : g_body
      assign vld_in = vld_r[i-1];
      assign n_in   = n_r[i-1];
      assign q_in   = q_r[i-1];
      assign rem_in = rem_r[i-1];
      assign side_i = side_r[i-1];
    end

    always_comb begin
      den = DREM_W'({side_i.v, 1'b0});
      for (int j = 0; j < 3; j++) begin
        rem_t = {rem_in[j][DREM_W-2:0], n_in[j][NUM_W-1]};
        if (rem_t >= den) begin
          rem_nxt[j] = rem_t - den;
          q_nxt[j]   = {q_in[j][NUM_W-2:0], 1'b1};
        end else begin
          rem_nxt[j] = rem_t;
          q_nxt[j]   = {q_in[j][NUM_W-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[i] <= 1'b0;
      end else begin
        vld_r[i] <= vld_in;
      end
      for (int j = 0; j < 3; j++) begin
        n_r[i][j] <= n_in[j] << 1;
      end
      q_r[i]    <= q_nxt;
      rem_r[i]  <= rem_nxt;
      side_r[i] <= side_i;
    end
  end

  assign out_vld  = vld_r[NUM_W-1];
  assign quot     = q_r[NUM_W-1];
  assign side_out = side_r[NUM_W-1];

endmodule

// ===== hw/rtl/rotation_matrix_to_quaternion.sv =====
// rotation_matrix_to_quaternion: top level, largest-term matrix to quaternion converter.
// Instantiates rmq_front, rmq_sqrt and rmq_div; depends on rmq_pkg.
//
// Usage:
//   Input channel: drive in_m00..in_m22 (signed Q1.14) and pulse start. A
//   request is taken at every rising edge with start high and busy low. busy
//   is always low: the pipeline takes one matrix per clock, back to back.
//   Result channel: out_valid is high for exactly one cycle per request, with
//   out_qx/qy/qz/qw (signed Q1.14, saturated) and out_fault alongside.
//   out_fault is set with all components zero when the largest candidate
//   term is not positive.
//   Pipeline: two front stages, one stage per square root bit, one rounding
//   stage, one stage per quotient bit of the three-lane divider and an output
//   register.
//   Throughput: one request per clock; results leave in request order.
//   Reset: synchronous on rst_n low clears every valid bit; requests in
//   flight are dropped. The receiver cannot stall, so nothing is held back.
module rotation_matrix_to_quaternion (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  output logic            busy,
  input  rmq_pkg::word_t  in_m00,
  input  rmq_pkg::word_t  in_m01,
  input  rmq_pkg::word_t  in_m02,
  input  rmq_pkg::word_t  in_m10,
  input  rmq_pkg::word_t  in_m11,
  input  rmq_pkg::word_t  in_m12,
  input  rmq_pkg::word_t  in_m20,
  input  rmq_pkg::word_t  in_m21,
  input  rmq_pkg::word_t  in_m22,
  output logic            out_valid,
  output rmq_pkg::word_t  out_qx,
  output rmq_pkg::word_t  out_qy,
  output rmq_pkg::word_t  out_qz,
  output rmq_pkg::word_t  out_qw,
  output logic            out_fault
);
  import rmq_pkg::*;

  logic                fr_vld;
  logic [RAD_W-1:0]    fr_rad;
  sq_side_t            fr_side;

  logic                sq_vld;
  logic [ROOT_W-1:0]   sq_root;
  logic [SREM_W-1:0]   sq_rem;
  sq_side_t            sq_side;

  logic                  rd_vld_r;
  logic [2:0][NUM_W-1:0] rd_num_r, rd_num_nxt;
  dv_side_t              rd_side_r, rd_side_nxt;
  logic [V_W-1:0]        v_nxt;

  logic                  dv_vld;
  logic [2:0][NUM_W-1:0] dv_quot;
  dv_side_t              dv_side;

  word_t [2:0]  lane_q;
  word_t        v_sat;
  word_t [3:0]  comp;

  logic         out_valid_r, out_fault_r;
  word_t        qx_r, qy_r, qz_r, qw_r;

  assign busy = 1'b0;

  rmq_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (start && !busy),
    .mat      ({in_m22, in_m21, in_m20, in_m12, in_m11, in_m10, in_m02, in_m01, in_m00}),
    .out_vld  (fr_vld),
    .radicand (fr_rad),
    .side     (fr_side)
  );

  rmq_sqrt u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (fr_vld),
    .radicand (fr_rad),
    .side_in  (fr_side),
    .out_vld  (sq_vld),
    .root     (sq_root),
    .rem      (sq_rem),
    .side_out (sq_side)
  );

  // round the root to nearest, then build numerators 2n+v over divisor 2v
  always_comb begin
    logic [SUM_W-1:0] mag;
    logic [MAG_W-1:0] n;
    v_nxt = V_W'(sq_root) + V_W'(sq_rem > SREM_W'(sq_root));
    rd_side_nxt.best  = sq_side.best;
    rd_side_nxt.fault = sq_side.fault;
    rd_side_nxt.v     = v_nxt;
    for (int j = 0; j < 3; j++) begin
      rd_side_nxt.neg[j] = sq_side.lane_sum[j][SUM_W-1];
      mag = rd_side_nxt.neg[j] ? SUM_W'(-sq_side.lane_sum[j]) : SUM_W'(sq_side.lane_sum[j]);
      n   = MAG_W'(mag) << (FRAC_BITS - 2);
      rd_num_nxt[j] = NUM_W'({n, 1'b0}) + NUM_W'(v_nxt);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_vld_r <= 1'b0;
    end else begin
      rd_vld_r <= sq_vld;
    end
    rd_num_r  <= rd_num_nxt;
    rd_side_r <= rd_side_nxt;
  end

  rmq_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (rd_vld_r),
    .num      (rd_num_r),
    .side_in  (rd_side_r),
    .out_vld  (dv_vld),
    .quot     (dv_quot),
    .side_out (dv_side)
  );

  // sign and saturate each lane, then place lanes around the chosen component; zero all on a fault
  always_comb begin
    for (int j = 0; j < 3; j++) begin
      if (dv_side.neg[j]) begin
        if (dv_quot[j] > NUM_W'(Q_MAX + 1)) begin
          lane_q[j] = word_t'(-(Q_MAX + 1));
        end else begin
          lane_q[j] = word_t'(-dv_quot[j]);
        end
      end else if (dv_quot[j] > NUM_W'(Q_MAX)) begin
        lane_q[j] = word_t'(Q_MAX);
      end else begin
        lane_q[j] = word_t'(dv_quot[j]);
      end
    end
    v_sat = (dv_side.v > V_W'(Q_MAX)) ? word_t'(Q_MAX) : word_t'(dv_side.v);
    case (dv_side.best)
      SEL_X: comp = {lane_q[2], lane_q[1], lane_q[0], v_sat};
      SEL_Y: comp = {lane_q[2], lane_q[1], v_sat, lane_q[0]};
      SEL_Z: comp = {lane_q[2], v_sat, lane_q[1], lane_q[0]};
      default: comp = {v_sat, lane_q[2], lane_q[1], lane_q[0]};
    endcase
    if (dv_side.fault) begin
      comp = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= dv_vld;
    end
    qx_r        <= comp[0];
    qy_r        <= comp[1];
    qz_r        <= comp[2];
    qw_r        <= comp[3];
    out_fault_r <= dv_side.fault;
  end

  assign out_valid = out_valid_r;
  assign out_qx    = qx_r;
  assign out_qy    = qy_r;
  assign out_qz    = qz_r;
  assign out_qw    = qw_r;
  assign out_fault = out_fault_r;

  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##(LATENCY) out_valid)
    else $error("request did not emerge after the pipeline latency");

  a_fault_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_fault) |-> (out_qx == 0 && out_qy == 0 && out_qz == 0 && out_qw == 0))
    else $error("fault result carries non-zero components");

  a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(dv_vld))
    else $error("result strobe without a divider result behind it");

endmodule
